[rtl/core/c2hk_pkg.sv]
// Shared types, key codes and helpers of the character to keystroke encoder.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package c2hk_pkg;

  localparam logic [7:0]  KeyAlt   = 8'hA4;
  localparam logic [7:0]  KeyPlus  = 8'h6B;
  localparam logic [7:0]  KeyEnter = 8'h0D;
  localparam logic [15:0] CodeLf   = 16'd10;
  localparam logic [15:0] CodeCr   = 16'd13;

  localparam int unsigned DefaultQueueDepth = 2;

  // Step codes of the back sequencer for a hex-typed item.
  localparam logic [3:0] StepAltDown  = 4'd0;
  localparam logic [3:0] StepPlusDown = 4'd1;
  localparam logic [3:0] StepPlusUp   = 4'd2;
  localparam logic [3:0] StepDigit0   = 4'd3;

  typedef struct packed {
    logic        is_lf;
    logic [2:0]  ndig;
    logic [15:0] code;
  } c2hk_desc_t;

  function automatic logic [7:0] digit_key(input logic [3:0] d);
    logic [7:0] k;
    if (d < 4'd10) begin
      k = 8'h60 | {4'd0, d};
    end else begin
      k = 8'h40 | {4'd0, d - 4'd9};
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[rtl/core/c2hk_front.sv]
// Front end: accepts characters, drops carriage returns and builds a descriptor.
// Depends on c2hk_pkg; feeds c2hk_queue.
`default_nettype none

module c2hk_front (
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [15:0]          char_code_i,
  output logic                      push_o,
  output c2hk_pkg::c2hk_desc_t      desc_o,
  input  wire logic                 full_i
);

  logic is_cr;
  logic [2:0] ndig;

  always_comb begin
    if (char_code_i[15:12] != 4'd0) begin
      ndig = 3'd4;
    end else if (char_code_i[11:8] != 4'd0) begin
      ndig = 3'd3;
    end else if (char_code_i[7:4] != 4'd0) begin
      ndig = 3'd2;
    end else if (char_code_i[3:0] != 4'd0) begin
      ndig = 3'd1;
    end else begin
      ndig = 3'd0;
    end
  end

  assign is_cr        = (char_code_i == c2hk_pkg::CodeCr);
  assign in_stall_o   = full_i;
  assign push_o       = in_valid_i && !full_i && !is_cr;
  assign desc_o.is_lf = (char_code_i == c2hk_pkg::CodeLf);
  assign desc_o.ndig  = ndig;
  assign desc_o.code  = char_code_i;

endmodule

`default_nettype wire

[rtl/core/c2hk_queue.sv]
// Short descriptor queue between front and back ends.
// Depends on c2hk_pkg for the descriptor type.
`default_nettype none

module c2hk_queue #(
  parameter int unsigned Depth = c2hk_pkg::DefaultQueueDepth
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire c2hk_pkg::c2hk_desc_t push_desc_i,
  output logic                      full_o,
  output logic                      valid_o,
  input  wire logic                 pop_i,
  output c2hk_pkg::c2hk_desc_t      pop_desc_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  c2hk_pkg::c2hk_desc_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_desc_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/c2hk_back.sv]
// Back end: steps through the key events of one descriptor, one per cycle while
// out_stall_i does not hold the output, into a registered output stage. Depends on c2hk_pkg.
`default_nettype none

module c2hk_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_valid_i,
  output logic                      q_pop_o,
  input  wire c2hk_pkg::c2hk_desc_t q_desc_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [7:0]                vkey_o,
  output logic                      key_down_o,
  output logic                      last_event_o
);

  c2hk_pkg::c2hk_desc_t cur_q, cur_d;
  logic cur_valid_q, cur_valid_d;
  logic [3:0] step_q, step_d;
  logic out_valid_q, out_valid_d;
  logic [7:0] key_q, key_d;
  logic down_q, down_d, last_q, last_d;

  logic can_load, emit, last;
  logic [3:0] sidx, last_step;
  logic [1:0] pos;
  logic [3:0] nib;

  assign can_load  = !out_valid_q || !out_stall_i;
  assign emit      = cur_valid_q && can_load;
  assign sidx      = step_q - c2hk_pkg::StepDigit0;
  assign pos       = 2'((3'd4 - cur_q.ndig) + {1'b0, sidx[2:1]});
  assign last_step = {cur_q.ndig, 1'b0} + c2hk_pkg::StepDigit0;

  always_comb begin
    case (pos)
      2'd0:    nib = cur_q.code[15:12];
      2'd1:    nib = cur_q.code[11:8];
      2'd2:    nib = cur_q.code[7:4];
      default: nib = cur_q.code[3:0];
    endcase
  end

  always_comb begin
    if (cur_q.is_lf) begin
      key_d  = c2hk_pkg::KeyEnter;
      down_d = (step_q == 4'd0);
      last   = (step_q != 4'd0);
    end else begin
      last = (step_q == last_step);
      unique case (step_q)
        c2hk_pkg::StepAltDown: begin
          key_d  = c2hk_pkg::KeyAlt;
          down_d = 1'b1;
        end
        c2hk_pkg::StepPlusDown: begin
          key_d  = c2hk_pkg::KeyPlus;
          down_d = 1'b1;
        end
        c2hk_pkg::StepPlusUp: begin
          key_d  = c2hk_pkg::KeyPlus;
          down_d = 1'b0;
        end
        default: begin
          if (last) begin
            key_d  = c2hk_pkg::KeyAlt;
            down_d = 1'b0;
          end else begin
            key_d  = c2hk_pkg::digit_key(nib);
            down_d = !sidx[0];
          end
        end
      endcase
    end
    last_d = last;
  end

  assign q_pop_o = q_valid_i && (!cur_valid_q || (emit && last));

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    step_d      = step_q;
    if (emit) begin
      step_d = step_q + 1'b1;
      if (last) begin
        cur_valid_d = 1'b0;
      end
    end
    if (q_pop_o) begin
      cur_d       = q_desc_i;
      cur_valid_d = 1'b1;
      step_d      = '0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (can_load) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      key_q  <= key_d;
      down_q <= down_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign vkey_o       = key_q;
  assign key_down_o   = down_q;
  assign last_event_o = last_q;

  a_hex_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && !cur_q.is_lf |-> step_q <= 4'd11)
    else $error("hex step beyond the longest sequence");

  a_lf_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && cur_q.is_lf |-> step_q <= 4'd1)
    else $error("line feed step beyond enter up");

  a_last_frees_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && last && !q_valid_i |=> !cur_valid_q && out_valid_q && last_event_o)
    else $error("last event did not retire the item");

endmodule

`default_nettype wire

[rtl/core/char_to_hex_keystroke_encoder_core.sv]
// Character to hex keystroke encoder, top level.
// Depends on c2hk_pkg, c2hk_front, c2hk_queue and c2hk_back.
//
// Input channel: char_code_i with in_valid_i / in_stall_o. An item is taken
// at a clock edge where in_valid_i is high and in_stall_o is low.
// Output channel: vkey_o, key_down_o, last_event_o with out_valid_o /
// out_stall_i; one key event moves per cycle while out_stall_i is low, and
// last_event_o marks the final event of a character.
// A line feed gives Enter down and up, a carriage return gives no event,
// any other code gives Alt down, plus down/up, the significant hex digits
// down/up and Alt up: 4 to 12 events.
// When the back end is free, an item that is taken passes through the queue
// and the sequencer's descriptor register into the output stage. Throughput:
// one event per cycle while out_stall_i is low; the back sequencer, which
// walks one event a cycle, sets this rate. A new item can follow in
// the next cycle while the queue has room.
// Reset clears the queue, the sequencer and the output valid flag; nothing else
// needs clearing. While out_stall_i is high the output holds its event and
// the sequencer waits; the front keeps taking items until the queue fills.
`default_nettype none

module char_to_hex_keystroke_encoder_core #(
  parameter int unsigned QueueDepth = c2hk_pkg::DefaultQueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] char_code_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       vkey_o,
  output logic             key_down_o,
  output logic             last_event_o
);

  c2hk_pkg::c2hk_desc_t push_desc, pop_desc;
  logic push, full, q_valid, pop;

  c2hk_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .push_o      (push),
    .desc_o      (push_desc),
    .full_i      (full)
  );

  c2hk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .pop_desc_o  (pop_desc)
  );

  c2hk_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_pop_o      (pop),
    .q_desc_i     (pop_desc),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .vkey_o       (vkey_o),
    .key_down_o   (key_down_o),
    .last_event_o (last_event_o)
  );

endmodule

`default_nettype wire
